### rtl/snapva_pkg.sv
// ----------------------------------------------------------------------------
// Snapshot versioned array package
// Shared constants, codes and the controller state type.
// ----------------------------------------------------------------------------
package snapva_pkg;

    localparam int MAX_LENGTH   = 256;
    localparam int MAX_VERSIONS = 16;
    localparam int EPOCH_BITS   = 16;

    localparam int INDEX_W  = $clog2(MAX_LENGTH);
    localparam int SLOT_W   = $clog2(MAX_VERSIONS);
    localparam int CNT_W    = $clog2(MAX_VERSIONS + 1);
    localparam int ADDR_W   = INDEX_W + SLOT_W;
    localparam int LEN_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int QUERY_W  = 16;
    localparam int TAKEN_W  = 16;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

    localparam logic REG_ACTIVE_LENGTH = 1'b0;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SNAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COUNTER   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_WCHECK,
        S_SEARCH,
        S_COMPARE,
        S_RESP
    } state_t;

endpackage

### rtl/snapshot_versioned_array_unit.sv
// ----------------------------------------------------------------------------
// Snapshot versioned array unit
// An array of words that keeps per-entry version lists and answers reads of
// past snapshots by a binary search over the entry's versions in memory.
// A snapshot or an error goes from S_COUNT to S_RESP; a write that finds
// stored versions passes S_WCHECK; a read does one S_SEARCH, S_COMPARE pair per
// step of the search, each step reading the version memory. One item is in
// work at a time: no new item is taken until the last has left S_RESP.
// A new item is taken while a result waits on m_.
// Reset clears the epoch, the control state and the per-entry valid bits.
// ----------------------------------------------------------------------------
module snapshot_versioned_array_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: index[7:0], value[39:8], query_snapshot[55:40]
    input  logic [snapva_pkg::S_DATA_W-1:0]     s_tdata,
    // tuser: kind[1:0]
    input  logic [snapva_pkg::KIND_W-1:0]       s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: read_value[31:0], taken_snapshot[47:32], status[50:48], zero pad
    output logic [snapva_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [snapva_pkg::PADDR_W-1:0]      paddr,
    input  logic [snapva_pkg::PDATA_W-1:0]      pwdata,
    output logic [snapva_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IW = snapva_pkg::INDEX_W;
    localparam int SW = snapva_pkg::SLOT_W;
    localparam int CW = snapva_pkg::CNT_W;
    localparam int EW = snapva_pkg::EPOCH_BITS;
    localparam int VW = snapva_pkg::VALUE_W;
    localparam int QW = snapva_pkg::QUERY_W;

    snapva_pkg::state_t state_reg, state_next;

    logic [snapva_pkg::LEN_W-1:0]    active_length_reg;
    logic [EW-1:0]                   epoch_reg, epoch_next;
    logic [snapva_pkg::MAX_LENGTH-1:0] cnt_vld_reg;

    logic [snapva_pkg::KIND_W-1:0]   kind_reg;
    logic [IW-1:0]                   idx_reg;
    logic [VW-1:0]                   value_reg;
    logic [QW-1:0]                   query_reg;

    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   lo_reg, lo_next;
    logic [CW-1:0]                   hi_reg, hi_next;

    logic [VW-1:0]                   res_value_reg, res_value_next;
    logic [snapva_pkg::TAKEN_W-1:0]  res_taken_reg, res_taken_next;
    logic [snapva_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [snapva_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CW-1:0]                   cnt_mem [snapva_pkg::MAX_LENGTH];
    logic [CW-1:0]                   cnt_rd_reg;
    logic                            cnt_we;
    logic [CW-1:0]                   cnt_wdata;

    logic [EW+VW-1:0]                ver_mem [1 << snapva_pkg::ADDR_W];
    logic [EW+VW-1:0]                ver_rd_reg;
    logic                            ver_we;
    logic [snapva_pkg::ADDR_W-1:0]   ver_waddr;
    logic [snapva_pkg::ADDR_W-1:0]   ver_raddr;
    logic [EW+VW-1:0]                ver_wdata;

    logic                            s_accept;
    logic                            out_load;
    logic                            cfg_write;
    logic [CW-1:0]                   cnt_cur;
    logic [CW-1:0]                   cnt_dec;
    logic                            idx_ok;
    logic                            query_ok;
    logic                            epoch_full;
    logic [CW:0]                     mid_sum;
    logic [CW-1:0]                   mid;
    logic [CW-1:0]                   mid_inc;
    logic [EW-1:0]                   rd_epoch;
    logic [VW-1:0]                   rd_word;
    logic                            rd_le;
    logic [CW-1:0]                   lo_cmp;
    logic [CW-1:0]                   hi_cmp;

    assign s_tready  = (state_reg == snapva_pkg::S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == snapva_pkg::REG_ACTIVE_LENGTH);
    assign prdata    = (paddr[2] == snapva_pkg::REG_ACTIVE_LENGTH)
                       ? {{(snapva_pkg::PDATA_W - snapva_pkg::LEN_W){1'b0}}, active_length_reg}
                       : '0;

    assign cnt_cur    = cnt_vld_reg[idx_reg] ? cnt_rd_reg : '0;
    assign cnt_dec    = cnt_cur - CW'(1);
    assign idx_ok     = {1'b0, idx_reg} < active_length_reg;
    assign query_ok   = query_reg < epoch_reg;
    assign epoch_full = (epoch_reg == {EW{1'b1}});
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[CW:1];
    assign mid_inc    = mid + CW'(1);
    assign rd_epoch   = ver_rd_reg[EW+VW-1:VW];
    assign rd_word    = ver_rd_reg[VW-1:0];
    assign rd_le      = rd_epoch <= query_reg;
    assign lo_cmp     = rd_le ? mid_inc : lo_reg;
    assign hi_cmp     = rd_le ? hi_reg : mid;

    function automatic logic [SW-1:0] count_dec_slot(input logic [CW-1:0] n);
        logic [CW-1:0] d;
        d = n - CW'(1);
        return d[SW-1:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            snapva_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = snapva_pkg::S_COUNT;
                end
            end
            snapva_pkg::S_COUNT: begin
                state_next = snapva_pkg::S_RESP;
                if (kind_reg == snapva_pkg::KIND_WRITE && idx_ok && cnt_cur != '0) begin
                    state_next = snapva_pkg::S_WCHECK;
                end else if (kind_reg == snapva_pkg::KIND_READ && idx_ok && query_ok
                             && cnt_cur != '0) begin
                    state_next = snapva_pkg::S_SEARCH;
                end
            end
            snapva_pkg::S_WCHECK: begin
                state_next = snapva_pkg::S_RESP;
            end
            snapva_pkg::S_SEARCH: begin
                state_next = snapva_pkg::S_COMPARE;
            end
            snapva_pkg::S_COMPARE: begin
                state_next = (lo_cmp < hi_cmp) ? snapva_pkg::S_SEARCH : snapva_pkg::S_RESP;
            end
            snapva_pkg::S_RESP: begin
                if (out_load) begin
                    state_next = snapva_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = snapva_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        epoch_next      = epoch_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_value_next  = res_value_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_cur + CW'(1);
        ver_we          = 1'b0;
        ver_waddr       = {idx_reg, cnt_cur[SW-1:0]};
        ver_wdata       = {epoch_reg, value_reg};
        ver_raddr       = {idx_reg, mid[SW-1:0]};
        case (state_reg)
            snapva_pkg::S_COUNT: begin
                count_next      = cnt_cur;
                lo_next         = '0;
                hi_next         = cnt_cur;
                res_value_next  = '0;
                res_taken_next  = '0;
                res_status_next = snapva_pkg::ST_OK;
                ver_raddr       = {idx_reg, cnt_dec[SW-1:0]};
                case (kind_reg)
                    snapva_pkg::KIND_WRITE: begin
                        if (!idx_ok) begin
                            res_status_next = snapva_pkg::ST_BAD_INDEX;
                        end else if (cnt_cur == '0) begin
                            ver_we = 1'b1;
                            cnt_we = 1'b1;
                        end
                    end
                    snapva_pkg::KIND_SNAP: begin
                        if (epoch_full) begin
                            res_status_next = snapva_pkg::ST_COUNTER;
                        end else begin
                            res_taken_next = epoch_reg[snapva_pkg::TAKEN_W-1:0];
                            epoch_next     = epoch_reg + EW'(1);
                        end
                    end
                    snapva_pkg::KIND_READ: begin
                        if (!idx_ok) begin
                            res_status_next = snapva_pkg::ST_BAD_INDEX;
                        end else if (!query_ok) begin
                            res_status_next = snapva_pkg::ST_NOT_TAKEN;
                        end
                    end
                    default: begin
                        res_status_next = snapva_pkg::ST_OK;
                    end
                endcase
            end
            snapva_pkg::S_WCHECK: begin
                if (rd_epoch == epoch_reg) begin
                    ver_we    = 1'b1;
                    ver_waddr = {idx_reg, count_dec_slot(count_reg)};
                end else if (count_reg == CW'(snapva_pkg::MAX_VERSIONS)) begin
                    res_status_next = snapva_pkg::ST_FULL;
                end else begin
                    ver_we    = 1'b1;
                    ver_waddr = {idx_reg, count_reg[SW-1:0]};
                    cnt_we    = 1'b1;
                    cnt_wdata = count_reg + CW'(1);
                end
            end
            snapva_pkg::S_COMPARE: begin
                lo_next = lo_cmp;
                hi_next = hi_cmp;
                if (rd_le) begin
                    res_value_next = rd_word;
                end
            end
            snapva_pkg::S_RESP: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(snapva_pkg::M_DATA_W - VW - snapva_pkg::TAKEN_W
                                       - snapva_pkg::STATUS_W){1'b0}},
                                     res_status_reg, res_taken_reg, res_value_reg};
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= snapva_pkg::S_IDLE;
            active_length_reg <= snapva_pkg::LEN_RESET;
            epoch_reg         <= '0;
            cnt_vld_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write) begin
                active_length_reg <= pwdata[snapva_pkg::LEN_W-1:0];
            end
            if (cnt_we) begin
                cnt_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg      <= count_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_value_reg  <= res_value_next;
        res_taken_reg  <= res_taken_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        if (s_accept) begin
            kind_reg  <= s_tuser;
            idx_reg   <= s_tdata[IW-1:0];
            value_reg <= s_tdata[IW+VW-1:IW];
            query_reg <= s_tdata[IW+VW+QW-1:IW+VW];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[idx_reg] <= cnt_wdata;
        end
        if (s_accept) begin
            cnt_rd_reg <= cnt_mem[s_tdata[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ver_we) begin
            ver_mem[ver_waddr] <= ver_wdata;
        end
        ver_rd_reg <= ver_mem[ver_raddr];
    end

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ver_we |-> (idx_ok && kind_reg == snapva_pkg::KIND_WRITE))
        else $error("version store written for a rejected item");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == snapva_pkg::S_COMPARE) |-> (lo_reg < hi_reg
            && hi_reg <= CW'(snapva_pkg::MAX_VERSIONS)))
        else $error("binary search window out of bounds");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (cnt_wdata != '0 && cnt_wdata <= CW'(snapva_pkg::MAX_VERSIONS)))
        else $error("version count out of range");

    a_snap_epoch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == snapva_pkg::S_COUNT && kind_reg == snapva_pkg::KIND_SNAP
            && !epoch_full) |=> (epoch_reg == $past(epoch_reg) + EW'(1)))
        else $error("epoch did not advance on a snapshot");

endmodule
